/* design/itpr_pkg.sv */
// Shared types and constants for the idle timeout packet receiver.
package itpr_pkg;

    localparam int LEN_W = 7;

    // receiver state codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    // input function codes
    localparam logic [1:0] F_BYTE = 2'd0;
    localparam logic [1:0] F_TICK = 2'd1;
    localparam logic [1:0] F_READ = 2'd2;

    // result kind codes
    localparam logic [1:0] K_READY   = 2'd0;
    localparam logic [1:0] K_OVERRUN = 2'd1;
    localparam logic [1:0] K_BYTE    = 2'd2;
    localparam logic [1:0] K_EMPTY   = 2'd3;

    localparam logic [7:0] IDLE_LIMIT_RST = 8'd5;

    // one queued job for the back end: a single notice, or a drain of len bytes
    typedef struct packed {
        logic             drain;
        logic [1:0]       kind;
        logic [LEN_W-1:0] len;
    } t_cmd;

endpackage

/* design/itpr_front.sv */
// Front end: holds receiver state, writes bytes to the store, turns beats into jobs.
module itpr_front #(
    parameter int BUF_DEPTH = 64,
    parameter int AW        = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [1:0]                i_func,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_cfg_we,
    input  logic [7:0]                i_cfg_wdata,
    input  logic                      i_drain_done,
    output logic                      o_drain_pend,
    output logic                      o_push,
    output itpr_pkg::t_cmd            o_cmd,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [7:0]                o_wr_data
);

    localparam logic [itpr_pkg::LEN_W-1:0] DEPTH_C = itpr_pkg::LEN_W'(BUF_DEPTH);

    logic [1:0]                 r_state, n_state;
    logic [itpr_pkg::LEN_W-1:0] r_cnt, n_cnt;
    logic [7:0]                 r_timer, n_timer;
    logic [7:0]                 r_idle_limit;
    logic                       r_pend, n_pend;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_timer   = r_timer;
        n_pend    = r_pend;
        o_push    = 1'b0;
        o_cmd     = '{drain: 1'b0, kind: itpr_pkg::K_EMPTY, len: '0};
        o_wr_en   = 1'b0;
        o_wr_addr = r_cnt[AW-1:0];
        o_wr_data = i_rx_byte;
        if (i_drain_done) begin
            n_pend = 1'b0;
        end
        if (i_accept) begin
            case (i_func)
                itpr_pkg::F_BYTE: begin
                    if (r_state != itpr_pkg::ST_READY) begin
                        n_timer = '0;
                        n_state = itpr_pkg::ST_BUSY;
                        if (r_cnt < DEPTH_C) begin
                            o_wr_en = 1'b1;
                            n_cnt   = r_cnt + 1'b1;
                        end
                    end else begin
                        o_push = 1'b1;
                        o_cmd  = '{drain: 1'b0, kind: itpr_pkg::K_OVERRUN, len: r_cnt};
                    end
                end
                itpr_pkg::F_TICK: begin
                    if (r_state == itpr_pkg::ST_BUSY) begin
                        n_timer = r_timer + 8'd1;
                        if (n_timer > r_idle_limit) begin
                            n_state = itpr_pkg::ST_READY;
                            o_push  = 1'b1;
                            o_cmd   = '{drain: 1'b0, kind: itpr_pkg::K_READY, len: r_cnt};
                        end
                    end
                end
                itpr_pkg::F_READ: begin
                    o_push = 1'b1;
                    if (r_state == itpr_pkg::ST_READY && r_cnt != '0) begin
                        o_cmd  = '{drain: 1'b1, kind: itpr_pkg::K_BYTE, len: r_cnt};
                        n_pend = 1'b1;
                    end
                    if (r_state == itpr_pkg::ST_READY) begin
                        n_cnt   = '0;
                        n_state = itpr_pkg::ST_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_drain_pend = r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= itpr_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_timer      <= '0;
            r_pend       <= 1'b0;
            r_idle_limit <= itpr_pkg::IDLE_LIMIT_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_timer <= n_timer;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
        end
    end

    // bytes are only taken while no drain is outstanding
    a_no_byte_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_wr_en) else $error("store written during drain");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C) else $error("byte count above store depth");
    a_ready_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == itpr_pkg::ST_READY |-> r_cnt != '0) else $error("ready with empty packet");

endmodule

/* design/itpr_cmd_fifo.sv */
// Short job queue between front and back end.
module itpr_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itpr_pkg::t_cmd i_data,
    input  logic           i_pop,
    output itpr_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    itpr_pkg::t_cmd r_q [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    assign o_head  = r_q[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

/* design/itpr_back.sv */
// Back end: packet store, job execution and the result output register.
module itpr_back #(
    parameter int BUF_DEPTH = 64,
    parameter int AW        = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [7:0]                  i_wr_data,
    input  itpr_pkg::t_cmd              i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_drain_done,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_data,
    output logic [itpr_pkg::LEN_W-1:0]  o_length,
    output logic                        o_last
);

    logic [7:0]                 r_mem [BUF_DEPTH];
    logic [7:0]                 r_rd_data;
    logic [AW-1:0]              rd_addr;

    logic                       r_drain, n_drain;
    logic [AW-1:0]              r_idx, n_idx;
    logic [itpr_pkg::LEN_W-1:0] r_cnt, n_cnt;

    logic                       a_vld, a_last;
    logic [1:0]                 a_kind;
    logic [itpr_pkg::LEN_W-1:0] a_len;

    logic                       r_vld, r_last, r_is_byte;
    logic [1:0]                 r_kind;
    logic [itpr_pkg::LEN_W-1:0] r_len;

    always_comb begin
        n_drain      = r_drain;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        o_pop        = 1'b0;
        o_drain_done = 1'b0;
        rd_addr      = '0;
        a_vld        = 1'b0;
        a_kind       = itpr_pkg::K_EMPTY;
        a_len        = '0;
        a_last       = 1'b0;
        if (r_drain) begin
            rd_addr = r_idx;
            a_vld   = 1'b1;
            a_kind  = itpr_pkg::K_BYTE;
            a_len   = r_cnt;
            a_last  = (itpr_pkg::LEN_W'(r_idx) + 1'b1 == r_cnt);
            if (a_last) begin
                n_drain      = 1'b0;
                o_drain_done = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end else if (!i_empty) begin
            o_pop  = 1'b1;
            a_vld  = 1'b1;
            a_len  = i_head.len;
            if (i_head.drain) begin
                a_kind = itpr_pkg::K_BYTE;
                a_last = (i_head.len == itpr_pkg::LEN_W'(1));
                if (a_last) begin
                    o_drain_done = 1'b1;
                end else begin
                    n_drain = 1'b1;
                    n_idx   = AW'(1);
                    n_cnt   = i_head.len;
                end
            end else begin
                a_kind = i_head.kind;
                a_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= a_kind;
        r_len     <= a_len;
        r_last    <= a_last;
        r_is_byte <= a_vld && (a_kind == itpr_pkg::K_BYTE);
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_drain <= n_drain;
            r_vld   <= a_vld;
        end
    end

    assign o_valid  = r_vld;
    assign o_kind   = r_kind;
    assign o_data   = r_is_byte ? r_rd_data : 8'd0;
    assign o_length = r_len;
    assign o_last   = r_last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (itpr_pkg::LEN_W'(r_idx) < r_cnt)) else $error("drain index past count");
    a_drain_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |=> r_vld && r_kind == itpr_pkg::K_BYTE) else $error("drain cycle lost a beat");
    a_no_pop_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> !o_pop) else $error("job popped during drain");

endmodule

/* design/idle_timeout_packet_receiver.sv */
// Top level of the idle timeout packet receiver.
// Frames received bytes into packets by idle gap. One beat (byte, 1 ms tick or
// read request) is taken per cycle while busy is low. Results pass through the
// job queue and the output register, one per cycle, each on the o_ ports
// for exactly one cycle with o_valid high; the receiver cannot stall them.
// A read of a ready packet of N bytes drains the store at one byte a cycle,
// set by the single read port of the store; busy rises after the read beat
// and stays high until the last byte has been read out. busy also rises when
// the four-entry job queue fills.
module idle_timeout_packet_receiver #(
    parameter int BUF_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_data,
    output logic [6:0] o_length,
    output logic       o_last
);

    // store address width, at least one bit
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic           accept;
    logic           drain_pend, drain_done;
    logic           push, pop, q_empty, q_full;
    itpr_pkg::t_cmd push_cmd, head_cmd;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;

    // stall while the queue is full or a packet drain is pending or still reading the store
    assign busy   = q_full || drain_pend;
    assign accept = start && !busy;

    itpr_front #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_func),
        .i_rx_byte    (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_drain_done (drain_done),
        .o_drain_pend (drain_pend),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    itpr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    itpr_back #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_head       (head_cmd),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_drain_done (drain_done),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_length     (o_length),
        .o_last       (o_last)
    );

endmodule
